// ===== sv/pwbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pwbs_pkg: shared types and constants of the pulse width byte serializer
// Item and result layouts, register indexes and queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwbs_pkg;

  localparam int DATA_BITS = 8;
  localparam int BYTE_W    = 8;
  localparam int DUR_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LEAD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd2;

  localparam logic [DUR_W-1:0] LEAD_RST  = 8'd3;
  localparam logic [DUR_W-1:0] LONG_RST  = 8'd3;
  localparam logic [DUR_W-1:0] SHORT_RST = 8'd1;

  // Action codes of an input beat.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SEND = 1'b1;

  // Both queues hold two entries.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              is_send;
    logic [BYTE_W-1:0] byte_value;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

endpackage

// ===== sv/pwbs_front.sv =====
// ----------------------------------------------------------------------------
// pwbs_front: input side
// Accepts input beats, classifies each as tick or send request and holds
// them in a two-entry queue until the engine takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwbs_front
  import pwbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_action,
  input  logic [BYTE_W-1:0] in_byte_value,
  output logic              item_valid,
  output item_t             item,
  input  logic              item_take
);

  item_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;
  item_t              new_item;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_comb begin
    new_item.is_send    = (in_action == ACT_SEND);
    new_item.byte_value = in_byte_value;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== sv/pwbs_engine.sv =====
// ----------------------------------------------------------------------------
// pwbs_engine: frame sequencer
// Holds the duration registers and the frame state, and turns each item
// into one result beat while the result queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwbs_engine
  import pwbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_wdata,
  input  logic                 item_valid,
  input  item_t                item,
  output logic                 item_take,
  input  logic                 res_room,
  output logic                 res_push,
  output result_t              res
);

  localparam int BIT_IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_HIGH  = 3'd2;
  localparam logic [2:0] PH_LOW   = 3'd3;
  localparam logic [2:0] PH_CLOSE = 3'd4;

  logic [DUR_W-1:0]     lead_r, long_r, short_r;
  logic [2:0]           phase_r, phase_nxt;
  logic [DUR_W-1:0]     tick_r, tick_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic                 line_r, line_nxt;
  logic                 done;
  logic                 rej;
  logic [DUR_W:0]       cnt;
  logic [DUR_W-1:0]     dur;
  logic                 cur_one;

  function automatic logic [DUR_W-1:0] eff_dur(input logic [DUR_W-1:0] d);
    eff_dur = (d == '0) ? DUR_W'(1) : d;
  endfunction

  assign item_take = item_valid && res_room;
  assign res_push  = item_take;
  assign cur_one   = shift_r[0];
  assign cnt       = {1'b0, tick_r} + 1'b1;

  always_comb begin
    unique case (phase_r)
      PH_HIGH: dur = eff_dur(cur_one ? long_r : short_r);
      PH_LOW:  dur = eff_dur(cur_one ? short_r : long_r);
      default: dur = eff_dur(lead_r);
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    line_nxt  = line_r;
    done      = 1'b0;
    rej       = 1'b0;
    if (item.is_send) begin
      if (phase_r == PH_IDLE) begin
        shift_nxt = DATA_BITS'(item.byte_value);
        bit_nxt   = '0;
        tick_nxt  = '0;
        line_nxt  = 1'b0;
        phase_nxt = PH_START;
      end else begin
        rej = 1'b1;
      end
    end else if (phase_r != PH_IDLE) begin
      if (cnt >= {1'b0, dur}) begin
        tick_nxt = '0;
        unique case (phase_r)
          PH_START: begin
            phase_nxt = PH_HIGH;
            line_nxt  = 1'b1;
          end
          PH_HIGH: begin
            phase_nxt = PH_LOW;
            line_nxt  = 1'b0;
          end
          PH_LOW: begin
            shift_nxt = shift_r >> 1;
            line_nxt  = 1'b1;
            // The last data bit hands over to the closing high period.
            if (bit_r == BIT_IDX_W'(DATA_BITS - 1)) begin
              bit_nxt   = '0;
              phase_nxt = PH_CLOSE;
            end else begin
              bit_nxt   = bit_r + 1'b1;
              phase_nxt = PH_HIGH;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            line_nxt  = 1'b1;
            bit_nxt   = '0;
            done      = 1'b1;
          end
        endcase
      end else begin
        tick_nxt = cnt[DUR_W-1:0];
      end
    end
  end

  always_comb begin
    res.line_level = line_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.frame_done = done;
    res.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= LEAD_RST;
      long_r  <= LONG_RST;
      short_r <= SHORT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEAD:  lead_r  <= cfg_wdata;
        REG_LONG:  long_r  <= cfg_wdata;
        REG_SHORT: short_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      line_r  <= 1'b1;
    end else if (item_take) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// ===== sv/pwbs_outq.sv =====
// ----------------------------------------------------------------------------
// pwbs_outq: result queue
// Two-entry queue of result beats that decouples the engine from the
// consumer on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwbs_outq
  import pwbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_push,
  input  result_t res,
  output logic    res_room,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign res_room = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = res_push && res_room;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

endmodule

// ===== sv/pulse_width_byte_serializer.sv =====
// ----------------------------------------------------------------------------
// pulse_width_byte_serializer: pulse width encoder for a one-wire command line
// Path: an accepted input beat is held in the input queue, turned into a result
// beat by the engine while the result queue has room, and held in the result queue.
// Throughput: one beat per cycle while an input beat waits and the result queue has room.
// Reset (synchronous, rst_n low): both queues empty, line high, frame idle,
// durations back to lead 3, long 3, short 1 ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_width_byte_serializer
  import pwbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_action,
  input  logic [BYTE_W-1:0]    in_byte_value,
  output logic                 empty,
  input  logic                 pop,
  output logic                 out_line_level,
  output logic                 out_busy_res,
  output logic                 out_frame_done,
  output logic                 out_rejected,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_wdata
);

  logic    item_valid;
  item_t   item;
  logic    item_take;
  logic    res_room;
  logic    res_push;
  result_t res;
  result_t head;

  pwbs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take)
  );

  pwbs_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_room   (res_room),
    .res_push   (res_push),
    .res        (res)
  );

  pwbs_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_room (res_room),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign out_line_level = head.line_level;
  assign out_busy_res   = head.busy_res;
  assign out_frame_done = head.frame_done;
  assign out_rejected   = head.rejected;

  // The engine must never produce a beat that the result queue cannot hold.
  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> res_room)
    else $error("result produced while result queue full");

  // A frame that just ended leaves the line high and the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_done) |-> (!out_busy_res && out_line_level))
    else $error("frame end reported while still busy");

  // Only a request that meets a running frame is rejected.
  a_reset_busy_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.rejected) |-> (res.busy_res && item.is_send))
    else $error("rejection without a running frame");

  // Right after reset is released nothing is waiting on either side.
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

// ===== test/pulse_width_byte_serializer_tb.sv =====
// ----------------------------------------------------------------------------
// pulse_width_byte_serializer_tb: self-checking bench for the serializer
// Feeds tick and send beats through the input queue and predicts every result
// beat: line level, busy, frame end and rejected request. The durations are
// changed between runs while no beat is in flight, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_width_byte_serializer_tb;
  import pwbs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned STALL_CYCLES   = 150;

  typedef enum logic [2:0] {FP_IDLE, FP_START, FP_HIGH, FP_LOW, FP_CLOSE} frame_phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic                 in_action = ACT_TICK;
  logic [BYTE_W-1:0]    in_byte_value = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 out_line_level;
  logic                 out_busy_res;
  logic                 out_frame_done;
  logic                 out_rejected;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LEAD;
  logic [DUR_W-1:0]     cfg_wdata = '0;

  pulse_width_byte_serializer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_action      (in_action),
    .in_byte_value  (in_byte_value),
    .empty          (empty),
    .pop            (pop),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_frame_done (out_frame_done),
    .out_rejected   (out_rejected),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predicted copy of the durations and of the frame sequencer.
  logic [DUR_W-1:0] lead_dur, long_dur, short_dur;
  frame_phase_t     line_phase;
  logic [7:0]       tick_cnt;
  int unsigned      bit_pos;
  logic [31:0]      shift_bits;
  logic             line_now;

  item_t       pending_beats[$];
  result_t     line_results_due[$];
  item_t       next_beat;
  int unsigned items_queued = 0;
  int unsigned beats_in = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned in_gap_max = 0;
  int unsigned out_gap_max = 0;
  int unsigned stall_left = 0;
  logic        stall_request = 1'b0;
  logic        stall_done = 1'b0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;

  function automatic int unsigned ticks_of(input logic [DUR_W-1:0] d);
    // A zero duration behaves as one tick.
    return (d == '0) ? 1 : d;
  endfunction

  function automatic int unsigned phase_span();
    logic one_bit;
    one_bit = shift_bits[0];
    case (line_phase)
      FP_START, FP_CLOSE: return ticks_of(lead_dur);
      FP_HIGH:            return ticks_of(one_bit ? long_dur : short_dur);
      default:            return ticks_of(one_bit ? short_dur : long_dur);
    endcase
  endfunction

  function automatic int unsigned frame_ticks();
    return 2 * ticks_of(lead_dur) + DATA_BITS * (ticks_of(long_dur) + ticks_of(short_dur));
  endfunction

  function automatic result_t predict_line(input logic act, input logic [BYTE_W-1:0] value);
    result_t     r;
    int unsigned cnt;
    r = '0;
    if (act == ACT_SEND) begin
      if (line_phase == FP_IDLE) begin
        shift_bits = 32'(value);
        bit_pos    = 0;
        tick_cnt   = '0;
        line_now   = 1'b0;
        line_phase = FP_START;
      end else begin
        r.rejected = 1'b1;
      end
    end else if (line_phase != FP_IDLE) begin
      cnt = int'(tick_cnt) + 1;
      // A duration lowered mid-phase ends the phase on the next tick.
      if (cnt >= phase_span()) begin
        tick_cnt = '0;
        case (line_phase)
          FP_START: begin
            line_phase = FP_HIGH;
            line_now   = 1'b1;
          end
          FP_HIGH: begin
            line_phase = FP_LOW;
            line_now   = 1'b0;
          end
          FP_LOW: begin
            shift_bits = shift_bits >> 1;
            bit_pos++;
            if (bit_pos >= DATA_BITS) begin
              line_phase = FP_CLOSE;
            end else begin
              line_phase = FP_HIGH;
            end
            line_now = 1'b1;
          end
          default: begin
            line_phase   = FP_IDLE;
            line_now     = 1'b1;
            bit_pos      = 0;
            r.frame_done = 1'b1;
          end
        endcase
      end else begin
        tick_cnt = 8'(cnt);
      end
    end
    r.line_level = line_now;
    r.busy_res   = (line_phase != FP_IDLE);
    return r;
  endfunction

  task automatic compare_bit(input string field, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatches++;
    end
  endtask

  // Sender: holds a beat until it is taken, then waits a random gap.
  always @(negedge clk) begin
    if (!push || in_taken) begin
      if (in_wait > 0) begin
        push <= 1'b0;
        in_wait--;
      end else if (pending_beats.size() > 0) begin
        next_beat     = pending_beats.pop_front();
        push          <= 1'b1;
        in_action     <= next_beat.is_send;
        in_byte_value <= next_beat.byte_value;
        in_wait       = $urandom_range(0, in_gap_max);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random gap after each beat, plus one long hold-off on request.
  always @(negedge clk) begin
    if (stall_request && !stall_done) begin
      stall_left = STALL_CYCLES;
      stall_done = 1'b1;
    end
    if (out_taken) begin
      out_wait = $urandom_range(0, out_gap_max);
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Monitor: predicts on every input beat and checks every result beat.
  always @(posedge clk) begin
    in_taken  <= push && !full;
    out_taken <= pop && !empty;
    if (rst_n) begin
      if (push && !full) begin
        line_results_due.push_back(predict_line(in_action, in_byte_value));
        beats_in++;
      end
      if (pop && !empty) begin
        if (line_results_due.size() == 0) begin
          $error("result beat arrived with no prediction pending");
          mismatches++;
        end else begin
          compare_bit("line_level", line_results_due[0].line_level, out_line_level);
          compare_bit("busy_res", line_results_due[0].busy_res, out_busy_res);
          compare_bit("frame_done", line_results_due[0].frame_done, out_frame_done);
          compare_bit("rejected", line_results_due[0].rejected, out_rejected);
          void'(line_results_due.pop_front());
        end
      end
      if ((push && !full) || (pop && !empty) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("no beat accepted for %0d cycles", idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic add_item(input logic act, input logic [BYTE_W-1:0] value);
    item_t it;
    it.is_send    = act;
    it.byte_value = value;
    pending_beats.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_LEAD: lead_dur = value;
      REG_LONG: long_dur = value;
      default:  short_dur = value;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_durations(input logic [DUR_W-1:0] lead, input logic [DUR_W-1:0] long_d,
                               input logic [DUR_W-1:0] short_d);
    write_reg(REG_LEAD, lead);
    write_reg(REG_LONG, long_d);
    write_reg(REG_SHORT, short_d);
    @(posedge clk);
  endtask

  // Mostly whole frames with random bytes; some are cut short, some get
  // trailing idle ticks, and stray requests land in the middle of frames.
  task automatic queue_frames(input int unsigned budget);
    int unsigned n;
    int unsigned span;
    n = 0;
    while (n < budget) begin
      add_item(ACT_SEND, BYTE_W'($urandom_range(0, 255)));
      n++;
      span = frame_ticks();
      case ($urandom_range(0, 9))
        0: span = $urandom_range(0, span);
        1: span = span + $urandom_range(1, 6);
        default: ;
      endcase
      for (int unsigned k = 0; k < span; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          add_item(ACT_SEND, BYTE_W'($urandom_range(0, 255)));
          n++;
        end
        add_item(ACT_TICK, BYTE_W'($urandom_range(0, 255)));
      end
      n += span;
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (beats_in != items_queued || line_results_due.size() != 0);
    // Let the pipeline settle before touching the registers.
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int phase_no;
    lead_dur   = LEAD_RST;
    long_dur   = LONG_RST;
    short_dur  = SHORT_RST;
    line_phase = FP_IDLE;
    tick_cnt   = '0;
    bit_pos    = 0;
    shift_bits = '0;
    line_now   = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, all-ones frame with a request rejected while busy,
    // then an all-zeros frame left running with every duration at zero.
    set_durations('0, '0, '0);
    add_item(ACT_TICK, 8'hFF);
    add_item(ACT_SEND, 8'hFF);
    add_item(ACT_SEND, 8'h00);
    repeat (frame_ticks()) add_item(ACT_TICK, 8'h00);
    add_item(ACT_SEND, 8'h00);
    repeat (3) add_item(ACT_TICK, 8'hFF);
    wait_drained();

    // Longest durations while that frame is still running.
    set_durations(8'd255, 8'd255, 8'd255);
    in_gap_max  = 8;
    out_gap_max = 8;
    repeat (15) add_item(ACT_TICK, BYTE_W'($urandom_range(0, 255)));
    add_item(ACT_SEND, BYTE_W'($urandom_range(0, 255)));
    repeat (15) add_item(ACT_TICK, BYTE_W'($urandom_range(0, 255)));
    wait_drained();

    // Shrinking the durations below the running count ends the phase at once.
    set_durations(8'd2, 8'd1, 8'd1);
    queue_frames(60);
    wait_drained();

    for (phase_no = 0; phase_no < 5; phase_no++) begin
      set_durations(DUR_W'($urandom_range(1, 4)), DUR_W'($urandom_range(0, 5)),
                    DUR_W'($urandom_range(0, 3)));
      in_gap_max  = (phase_no % 2 == 0) ? 0 : 8;
      out_gap_max = (phase_no == 3) ? 0 : 8;
      if (phase_no == 2) begin
        stall_request = 1'b1;
      end
      queue_frames(80);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (line_results_due.size() != 0) begin
      $error("%0d predicted results never arrived", line_results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
